// File: sv/smms_pkg.sv
package smms_pkg;

  // Fixed field widths of the block.
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned FRAC_W    = COEF_W - 2;
  localparam int unsigned SLEW_W    = 16;
  localparam int unsigned SLOTS     = 8;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned CNT_W     = SLOT_W + 1;
  localparam int unsigned CODE_W    = 4;
  localparam int unsigned CH_W      = 3;
  localparam int unsigned LANE_W    = 16;
  localparam int unsigned BUS_W     = 64;
  localparam int unsigned TAB_DEPTH = 16;
  localparam int unsigned TAB_AW    = 4;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Datapath widths. A blended coefficient scaled by the ramp length stays
  // within 33 bits; the numerator of the division stays below 2^48.
  localparam int unsigned PROD_W    = COEF_W + SLEW_W + 1;
  localparam int unsigned EL_W      = PROD_W + 1;
  localparam int unsigned TERM_W    = SAMPLE_W + EL_W;
  localparam int unsigned BUSS_W    = LANE_W + SLEW_W + 1;
  localparam int unsigned ACC_W     = TERM_W;
  localparam int unsigned MAG_W     = ACC_W - FRAC_W;
  localparam int unsigned QUO_W     = 18;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_W);
  localparam logic [TAB_AW-1:0] UNITY_LEFT_IDX  = TAB_AW'(0);
  localparam logic [TAB_AW-1:0] UNITY_RIGHT_IDX = TAB_AW'(3);

  localparam logic [SLEW_W-1:0] SLEW_RESET  = '0;
  localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(2);
  localparam logic [CFG_W-1:0]  MAP_RESET   = 32'hFFFF_FF10;

  localparam logic [QUO_W-1:0] MAG_HI = QUO_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic [QUO_W-1:0] MAG_LO = QUO_W'(1 << (SAMPLE_W - 1));

  typedef enum logic [1:0] {
    OP_MIX   = 2'd0,
    OP_COEF  = 2'd1,
    OP_BEGIN = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLEW_FRAMES   = 2'd0,
    CFG_CHANNEL_COUNT = 2'd1,
    CFG_CHANNEL_MAP   = 2'd2
  } cfg_e;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_SCAN = 9'b000000010,
    ST_MUL  = 9'b000000100,
    ST_SUM  = 9'b000001000,
    ST_TERM = 9'b000010000,
    ST_ACC  = 9'b000100000,
    ST_DIVP = 9'b001000000,
    ST_DIV  = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_e;

  typedef struct packed {
    logic              frame_start;
    logic              coef_wr;
    logic              tab_copy;
    logic              ramp_adv;
    logic              mul_en;
    logic              sum_en;
    logic              term_en;
    logic              acc_load;
    logic              acc_add;
    logic              div_init;
    logic              div_step;
    logic              out_load;
    logic              side;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] pos;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic [SLOTS-1:0] known;
    logic             out_busy;
  } status_t;

endpackage

// File: sv/smms_ctrl.sv
module smms_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            op_i,
  input  smms_pkg::status_t     status_i,
  output smms_pkg::cmd_t        cmd_o
);

  smms_pkg::state_e state_q, state_d;
  logic [smms_pkg::CNT_W-1:0]     slot_q, slot_d;
  logic [smms_pkg::SLOT_W-1:0]    pos_q, pos_d;
  logic                           side_q, side_d;
  logic [smms_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [smms_pkg::SLOT_W-1:0]    slot_idx;

  assign slot_idx   = slot_q[smms_pkg::SLOT_W-1:0];
  assign in_stall_o = (state_q != smms_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    pos_d   = pos_q;
    side_d  = side_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.side = side_q;
    cmd_o.slot = slot_idx;
    cmd_o.pos  = pos_q;
    // Last word of the frame when no known slot follows this one.
    cmd_o.last = ((status_i.known >> slot_idx) >> 1) == '0;

    unique case (state_q)
      smms_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (op_i)
            smms_pkg::OP_MIX: begin
              cmd_o.frame_start = 1'b1;
              slot_d  = '0;
              pos_d   = '0;
              side_d  = 1'b0;
              state_d = smms_pkg::ST_SCAN;
            end
            smms_pkg::OP_COEF:  cmd_o.coef_wr  = 1'b1;
            smms_pkg::OP_BEGIN: cmd_o.tab_copy = 1'b1;
            default: ;
          endcase
        end
      end
      smms_pkg::ST_SCAN: begin
        if (slot_q == smms_pkg::CNT_W'(smms_pkg::SLOTS)) begin
          cmd_o.ramp_adv = 1'b1;
          state_d = smms_pkg::ST_IDLE;
        end else if (status_i.known[slot_idx]) begin
          side_d  = 1'b0;
          state_d = smms_pkg::ST_MUL;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      smms_pkg::ST_MUL: begin
        cmd_o.mul_en  = 1'b1;
        // The left term is folded in while the right coefficient is formed.
        cmd_o.acc_add = side_q;
        state_d = smms_pkg::ST_SUM;
      end
      smms_pkg::ST_SUM: begin
        cmd_o.sum_en   = 1'b1;
        cmd_o.acc_load = !side_q;
        state_d = smms_pkg::ST_TERM;
      end
      smms_pkg::ST_TERM: begin
        cmd_o.term_en = 1'b1;
        if (side_q) begin
          state_d = smms_pkg::ST_ACC;
        end else begin
          side_d  = 1'b1;
          state_d = smms_pkg::ST_MUL;
        end
      end
      smms_pkg::ST_ACC: begin
        cmd_o.acc_add = 1'b1;
        state_d = smms_pkg::ST_DIVP;
      end
      smms_pkg::ST_DIVP: begin
        cmd_o.div_init = 1'b1;
        cnt_d   = '0;
        state_d = smms_pkg::ST_DIV;
      end
      smms_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == smms_pkg::DIV_CNT_W'(smms_pkg::QUO_W - 1)) begin
          state_d = smms_pkg::ST_FIN;
        end
      end
      smms_pkg::ST_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          pos_d   = pos_q + 1'b1;
          slot_d  = slot_q + 1'b1;
          side_d  = 1'b0;
          state_d = smms_pkg::ST_SCAN;
        end
      end
      default: state_d = smms_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smms_pkg::ST_IDLE;
      slot_q  <= '0;
      pos_q   <= '0;
      side_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      pos_q   <= pos_d;
      side_q  <= side_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: sv/smms_dp.sv
module smms_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  smms_pkg::cmd_t                         cmd_i,
  output smms_pkg::status_t                      status_o,
  input  logic                                   cfg_we_i,
  input  logic [smms_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [smms_pkg::CFG_W-1:0]             cfg_data_i,
  input  logic signed [smms_pkg::SAMPLE_W-1:0]   sample_left_i,
  input  logic signed [smms_pkg::SAMPLE_W-1:0]   sample_right_i,
  input  logic [smms_pkg::BUS_W-1:0]             bus_in_low_i,
  input  logic [smms_pkg::BUS_W-1:0]             bus_in_high_i,
  input  logic [smms_pkg::CH_W-1:0]              coef_channel_i,
  input  logic                                   coef_side_i,
  input  logic signed [smms_pkg::COEF_W-1:0]     coef_value_i,
  input  logic                                   out_stall_i,
  output logic                                   out_valid_o,
  output logic [smms_pkg::SLOT_W-1:0]            position_o,
  output logic [smms_pkg::CH_W-1:0]              channel_id_o,
  output logic signed [smms_pkg::SAMPLE_W-1:0]   bus_out_o,
  output logic                                   saturated_o,
  output logic                                   last_o
);

  localparam int unsigned SW = smms_pkg::SLEW_W;

  // Configuration registers.
  logic [SW-1:0]                  slew_frames_q;
  logic [smms_pkg::CNT_W-1:0]     channel_count_q;
  logic [smms_pkg::CFG_W-1:0]     channel_map_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slew_frames_q   <= smms_pkg::SLEW_RESET;
      channel_count_q <= smms_pkg::COUNT_RESET;
      channel_map_q   <= smms_pkg::MAP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        smms_pkg::CFG_SLEW_FRAMES:   slew_frames_q   <= cfg_data_i[SW-1:0];
        smms_pkg::CFG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[smms_pkg::CNT_W-1:0];
        smms_pkg::CFG_CHANNEL_MAP:   channel_map_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Slots in use that carry a channel id; codes 8 and up are skipped.
  logic [smms_pkg::CNT_W-1:0] slots_used;
  logic [smms_pkg::SLOTS-1:0] known;

  always_comb begin
    slots_used = (channel_count_q > smms_pkg::CNT_W'(smms_pkg::SLOTS)) ?
                 smms_pkg::CNT_W'(smms_pkg::SLOTS) : channel_count_q;
    for (int c = 0; c < smms_pkg::SLOTS; c++) begin
      known[c] = (smms_pkg::CNT_W'(c) < slots_used) &&
                 !channel_map_q[c*smms_pkg::CODE_W + smms_pkg::CH_W];
    end
  end

  // Coefficient tables, one read port each.
  logic signed [smms_pkg::COEF_W-1:0] coef_q [smms_pkg::TAB_DEPTH];
  logic signed [smms_pkg::COEF_W-1:0] old_q  [smms_pkg::TAB_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < smms_pkg::TAB_DEPTH; i++) begin
        if (smms_pkg::TAB_AW'(i) == smms_pkg::UNITY_LEFT_IDX ||
            smms_pkg::TAB_AW'(i) == smms_pkg::UNITY_RIGHT_IDX) begin
          coef_q[i] <= smms_pkg::COEF_ONE;
          old_q[i]  <= smms_pkg::COEF_ONE;
        end else begin
          coef_q[i] <= '0;
          old_q[i]  <= '0;
        end
      end
    end else begin
      if (cmd_i.coef_wr) begin
        coef_q[{coef_channel_i, coef_side_i}] <= coef_value_i;
      end
      if (cmd_i.tab_copy) begin
        old_q <= coef_q;
      end
    end
  end

  // Ramp position and the frame's latched operands.
  logic [SW-1:0] slew_pos_q;
  logic          ramp_q;
  logic          ramp_now;
  logic [SW-1:0] s_q, p_q;
  logic signed [smms_pkg::SAMPLE_W-1:0] left_q, right_q;
  logic [2*smms_pkg::BUS_W-1:0] bus_q;

  assign ramp_now = (slew_frames_q != '0) && (slew_pos_q < slew_frames_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slew_pos_q <= '0;
      ramp_q     <= 1'b0;
    end else begin
      if (cmd_i.frame_start) begin
        ramp_q <= ramp_now;
      end
      if (cmd_i.tab_copy) begin
        slew_pos_q <= '0;
      end else if (cmd_i.ramp_adv && ramp_q) begin
        slew_pos_q <= slew_pos_q + 1'b1;
      end
    end
  end

  // Outside a ramp the blend collapses to the new coefficient over one.
  always_ff @(posedge clk_i) begin
    if (cmd_i.frame_start) begin
      s_q     <= ramp_now ? slew_frames_q : SW'(1);
      p_q     <= ramp_now ? slew_pos_q : SW'(1);
      left_q  <= sample_left_i;
      right_q <= sample_right_i;
      bus_q   <= {bus_in_high_i, bus_in_low_i};
    end
  end

  // Blend, product and accumulate.
  logic [smms_pkg::CH_W-1:0]          ch;
  logic [smms_pkg::TAB_AW-1:0]        rd_idx;
  logic signed [smms_pkg::COEF_W-1:0] new_rd, old_rd;
  logic signed [smms_pkg::LANE_W-1:0] lane;
  logic [SW-1:0]                      s_minus_p;

  assign ch        = channel_map_q[cmd_i.slot*smms_pkg::CODE_W +: smms_pkg::CH_W];
  assign rd_idx    = {ch, cmd_i.side};
  assign new_rd    = coef_q[rd_idx];
  assign old_rd    = old_q[rd_idx];
  assign lane      = $signed(bus_q[cmd_i.pos*smms_pkg::LANE_W +: smms_pkg::LANE_W]);
  assign s_minus_p = s_q - p_q;

  logic signed [smms_pkg::PROD_W-1:0] pa_q, pb_q;
  logic signed [smms_pkg::BUSS_W-1:0] buss_q;
  logic signed [smms_pkg::EL_W-1:0]   el_q;
  logic signed [smms_pkg::TERM_W-1:0] term_q;
  logic signed [smms_pkg::ACC_W-1:0]  acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      pa_q <= new_rd * $signed({1'b0, p_q});
      pb_q <= old_rd * $signed({1'b0, s_minus_p});
      if (!cmd_i.side) begin
        buss_q <= lane * $signed({1'b0, s_q});
      end
    end
    if (cmd_i.sum_en) begin
      el_q <= smms_pkg::EL_W'(pa_q) + smms_pkg::EL_W'(pb_q);
    end
    if (cmd_i.term_en) begin
      term_q <= (cmd_i.side ? right_q : left_q) * el_q;
    end
    if (cmd_i.acc_load) begin
      acc_q <= smms_pkg::ACC_W'(buss_q) <<< smms_pkg::FRAC_W;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + term_q;
    end
  end

  // Restoring divider on magnitudes: |num| / (S * 2^14) is taken as
  // floor(floor(|num| / 2^14) / S), then the sign is put back, which
  // truncates toward zero.
  logic [smms_pkg::ACC_W-1:0] acc_mag;
  logic [smms_pkg::MAG_W-1:0] dividend;
  logic [SW:0]                trial;
  logic                       fits;
  logic [SW-1:0]              rem_q;
  logic [smms_pkg::QUO_W-1:0] dvd_q;
  logic                       neg_q;

  assign acc_mag  = acc_q[smms_pkg::ACC_W-1] ? $unsigned(-acc_q) : $unsigned(acc_q);
  assign dividend = acc_mag[smms_pkg::ACC_W-1:smms_pkg::FRAC_W];
  assign trial    = {rem_q, dvd_q[smms_pkg::QUO_W-1]};
  assign fits     = trial >= {1'b0, s_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      neg_q <= acc_q[smms_pkg::ACC_W-1];
      rem_q <= dividend[smms_pkg::QUO_W+SW-1:smms_pkg::QUO_W];
      dvd_q <= dividend[smms_pkg::QUO_W-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? SW'(trial - {1'b0, s_q}) : trial[SW-1:0];
      dvd_q <= {dvd_q[smms_pkg::QUO_W-2:0], fits};
    end
  end

  // Clamp and output register.
  logic [smms_pkg::QUO_W-1:0]         neg_mag;
  logic                               sat;
  logic signed [smms_pkg::SAMPLE_W-1:0] clamped;

  assign neg_mag = -dvd_q;

  always_comb begin
    if (neg_q) begin
      sat     = dvd_q > smms_pkg::MAG_LO;
      clamped = sat ? $signed(smms_pkg::MAG_LO[smms_pkg::SAMPLE_W-1:0]) :
                      $signed(neg_mag[smms_pkg::SAMPLE_W-1:0]);
    end else begin
      sat     = dvd_q > smms_pkg::MAG_HI;
      clamped = sat ? $signed(smms_pkg::MAG_HI[smms_pkg::SAMPLE_W-1:0]) :
                      $signed(dvd_q[smms_pkg::SAMPLE_W-1:0]);
    end
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      position_o   <= cmd_i.pos;
      channel_id_o <= ch;
      bus_out_o    <= clamped;
      saturated_o  <= sat;
      last_o       <= cmd_i.last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.known    = known;
  assign status_o.out_busy = out_valid_q && out_stall_i;

endmodule

// File: sv/stereo_matrix_mixer_slew_core.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o   op, samples, bus words, coefficient
// out       output     out_valid_o/out_stall_i position, channel_id, bus_out, flags
// cfg       input      cfg_we_i               cfg_idx_i, cfg_data_i
//
// A coefficient write or a coefficient change keeps the core idle. A mix frame
// scans all eight slots whatever the count, and each known slot goes through
// the 18-step restoring divider of the ramp blend.
// Reset is asynchronous and restores the unity coefficient tables at once.
// A stalled result word holds the next slot in its last step; the input
// side stays stalled until the frame's work is done.
module stereo_matrix_mixer_slew_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             op_i,
  input  logic signed [smms_pkg::SAMPLE_W-1:0]   sample_left_i,
  input  logic signed [smms_pkg::SAMPLE_W-1:0]   sample_right_i,
  input  logic [smms_pkg::BUS_W-1:0]             bus_in_low_i,
  input  logic [smms_pkg::BUS_W-1:0]             bus_in_high_i,
  input  logic [smms_pkg::CH_W-1:0]              coef_channel_i,
  input  logic                                   coef_side_i,
  input  logic signed [smms_pkg::COEF_W-1:0]     coef_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [smms_pkg::SLOT_W-1:0]            position_o,
  output logic [smms_pkg::CH_W-1:0]              channel_id_o,
  output logic signed [smms_pkg::SAMPLE_W-1:0]   bus_out_o,
  output logic                                   saturated_o,
  output logic                                   last_o,
  input  logic                                   cfg_we_i,
  input  logic [smms_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [smms_pkg::CFG_W-1:0]             cfg_data_i
);

  smms_pkg::cmd_t    cmd;
  smms_pkg::status_t status;

  smms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  smms_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .sample_left_i  (sample_left_i),
    .sample_right_i (sample_right_i),
    .bus_in_low_i   (bus_in_low_i),
    .bus_in_high_i  (bus_in_high_i),
    .coef_channel_i (coef_channel_i),
    .coef_side_i    (coef_side_i),
    .coef_value_i   (coef_value_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .position_o     (position_o),
    .channel_id_o   (channel_id_o),
    .bus_out_o      (bus_out_o),
    .saturated_o    (saturated_o),
    .last_o         (last_o)
  );

  // A finished word never overwrites one that is still waiting.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_o && out_stall_i))
    else $error("result word overwritten while stalled");

  // An accepted mix request keeps the input side stalled in the next cycle.
  a_mix_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (op_i == smms_pkg::OP_MIX)) |=> in_stall_o)
    else $error("mix request did not start a frame");

  // The accumulator and divider see at most one operation per cycle.
  a_one_op : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.acc_load, cmd.acc_add, cmd.div_init, cmd.div_step, cmd.out_load}))
    else $error("conflicting datapath operations");

endmodule

// File: sim/tb_top.sv
module tb_top;
  import smms_pkg::*;

  localparam logic [1:0]        OP_IGNORED     = 2'd3;
  localparam logic [CODE_W-1:0] CODE_UNKNOWN   = 4'hF;
  localparam int unsigned       NUM_CHANNELS   = 8;
  localparam int unsigned       FRAME_CYCLES   = 300;
  localparam int unsigned       WATCHDOG_LIMIT = 4000;
  localparam int unsigned       RAND_PHASES    = 5;
  localparam int unsigned       PHASE_WORDS    = 38;

  typedef struct {
    logic [1:0]                 op;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic [BUS_W-1:0]           bus_lo;
    logic [BUS_W-1:0]           bus_hi;
    logic [CH_W-1:0]            ch;
    logic                       side;
    logic signed [COEF_W-1:0]   val;
    bit                         hold;
  } in_word_t;

  typedef struct {
    logic [SLOT_W-1:0]          pos;
    logic [CH_W-1:0]            ch;
    logic signed [SAMPLE_W-1:0] bus;
    logic                       sat;
    logic                       last;
  } out_word_t;

  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       in_valid_i     = 1'b0;
  logic                       in_stall_o;
  logic [1:0]                 op_i           = '0;
  logic signed [SAMPLE_W-1:0] sample_left_i  = '0;
  logic signed [SAMPLE_W-1:0] sample_right_i = '0;
  logic [BUS_W-1:0]           bus_in_low_i   = '0;
  logic [BUS_W-1:0]           bus_in_high_i  = '0;
  logic [CH_W-1:0]            coef_channel_i = '0;
  logic                       coef_side_i    = 1'b0;
  logic signed [COEF_W-1:0]   coef_value_i   = '0;
  logic                       out_valid_o;
  logic                       out_stall_i    = 1'b0;
  logic [SLOT_W-1:0]          position_o;
  logic [CH_W-1:0]            channel_id_o;
  logic signed [SAMPLE_W-1:0] bus_out_o;
  logic                       saturated_o;
  logic                       last_o;
  logic                       cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i      = CFG_SLEW_FRAMES;
  logic [CFG_W-1:0]           cfg_data_i     = '0;

  stereo_matrix_mixer_slew_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .sample_left_i  (sample_left_i),
    .sample_right_i (sample_right_i),
    .bus_in_low_i   (bus_in_low_i),
    .bus_in_high_i  (bus_in_high_i),
    .coef_channel_i (coef_channel_i),
    .coef_side_i    (coef_side_i),
    .coef_value_i   (coef_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .position_o     (position_o),
    .channel_id_o   (channel_id_o),
    .bus_out_o      (bus_out_o),
    .saturated_o    (saturated_o),
    .last_o         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Mixer state as the testbench sees it.
  logic signed [COEF_W-1:0] coef_tab [TAB_DEPTH];
  logic signed [COEF_W-1:0] old_tab  [TAB_DEPTH];
  logic [SLEW_W-1:0]        slew_pos;
  logic [SLEW_W-1:0]        slew_frames_m = SLEW_RESET;
  logic [CNT_W-1:0]         chan_count_m  = COUNT_RESET;
  logic [CFG_W-1:0]         chan_map_m    = MAP_RESET;

  in_word_t  in_words_q [$];
  out_word_t bus_results_q [$];
  in_word_t  cur_word;
  int unsigned idle_pct     = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors       = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Applies one accepted input word to the mixer state and queues the
  // bus values it will produce.
  task automatic mixer_apply(input in_word_t w);
    out_word_t                  res [SLOTS];
    int                         n;
    int unsigned                slots;
    logic [CODE_W-1:0]          code;
    logic [BUS_W-1:0]           src;
    logic signed [LANE_W-1:0]   lane;
    logic [TAB_AW-1:0]          idx;
    bit                         ramp;
    longint                     s, p, denom, bus, l, r, cn, co, el, er, num, q;
    case (w.op)
      OP_COEF: coef_tab[{w.ch, w.side}] = w.val;
      OP_BEGIN: begin
        old_tab = coef_tab;
        slew_pos = '0;
      end
      OP_MIX: begin
        ramp = (slew_frames_m != 0) && (slew_pos < slew_frames_m);
        s = ramp ? longint'(slew_frames_m) : 1;
        p = ramp ? longint'(slew_pos) : 0;
        denom = s * (longint'(1) << FRAC_W);
        l = longint'(w.left);
        r = longint'(w.right);
        slots = (chan_count_m > SLOTS) ? SLOTS : chan_count_m;
        n = 0;
        for (int c = 0; c < slots; c++) begin
          code = chan_map_m[CODE_W*c +: CODE_W];
          if (code != CODE_UNKNOWN && code < NUM_CHANNELS) begin
            src = (n < 4) ? w.bus_lo : w.bus_hi;
            lane = src[LANE_W*(n%4) +: LANE_W];
            bus = longint'(lane);
            idx = {code[CH_W-1:0], 1'b0};
            cn = longint'(coef_tab[idx]);
            co = longint'(old_tab[idx]);
            el = ramp ? cn * p + co * (s - p) : cn;
            idx = {code[CH_W-1:0], 1'b1};
            cn = longint'(coef_tab[idx]);
            co = longint'(old_tab[idx]);
            er = ramp ? cn * p + co * (s - p) : cn;
            num = bus * denom + l * el + r * er;
            q = num / denom;
            res[n].sat = 1'b0;
            if (q > 32767) begin
              q = 32767;
              res[n].sat = 1'b1;
            end else if (q < -32768) begin
              q = -32768;
              res[n].sat = 1'b1;
            end
            res[n].pos  = n[SLOT_W-1:0];
            res[n].ch   = code[CH_W-1:0];
            res[n].bus  = q[SAMPLE_W-1:0];
            res[n].last = 1'b0;
            n++;
          end
        end
        for (int k = 0; k < n; k++) begin
          if (k == n - 1) res[k].last = 1'b1;
          bus_results_q.push_back(res[k]);
        end
        if (ramp) slew_pos = slew_pos + 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string what, input logic signed [SAMPLE_W:0] want,
                             input logic signed [SAMPLE_W:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  task automatic write_reg(input cfg_e idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_SLEW_FRAMES:   slew_frames_m = data[SLEW_W-1:0];
      CFG_CHANNEL_COUNT: chan_count_m  = data[CNT_W-1:0];
      default:           chan_map_m    = data;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every word is sent and answered, then lets a whole frame's
  // worth of cycles pass, since a frame with no known slot answers nothing.
  task automatic wait_drained();
    while (in_words_q.size() != 0 || in_valid_i || bus_results_q.size() != 0)
      @(posedge clk_i);
    repeat (FRAME_CYCLES) @(posedge clk_i);
  endtask

  function automatic in_word_t filler_word();
    in_word_t w;
    w.op     = OP_MIX;
    w.left   = SAMPLE_W'($urandom);
    w.right  = SAMPLE_W'($urandom);
    w.bus_lo = {$urandom, $urandom};
    w.bus_hi = {$urandom, $urandom};
    w.ch     = CH_W'($urandom);
    w.side   = 1'($urandom);
    w.val    = COEF_W'($urandom);
    w.hold   = 1'b0;
    return w;
  endfunction

  function automatic in_word_t mk_mix(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
                                      input logic [BUS_W-1:0] lo, input logic [BUS_W-1:0] hi);
    in_word_t w;
    w = filler_word();
    w.left   = l;
    w.right  = r;
    w.bus_lo = lo;
    w.bus_hi = hi;
    return w;
  endfunction

  function automatic in_word_t mk_coef(input int unsigned ch, input bit side,
                                       input logic [COEF_W-1:0] val);
    in_word_t w;
    w = filler_word();
    w.op   = OP_COEF;
    w.ch   = ch[CH_W-1:0];
    w.side = side;
    w.val  = val;
    return w;
  endfunction

  function automatic in_word_t mk_ctl(input logic [1:0] op);
    in_word_t w;
    w = filler_word();
    w.op = op;
    return w;
  endfunction

  function automatic in_word_t rand_word(input bit hold);
    in_word_t    w;
    int unsigned pick;
    w = filler_word();
    pick = $urandom_range(0, 99);
    if (pick < 70) w.op = OP_MIX;
    else if (pick < 88) w.op = OP_COEF;
    else if (pick < 96) w.op = OP_BEGIN;
    else w.op = OP_IGNORED;
    if ($urandom_range(0, 7) == 0) w.left = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    if ($urandom_range(0, 7) == 0) w.right = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    if ($urandom_range(0, 3) == 0) w.val = $urandom_range(0, 1) ? COEF_ONE : -COEF_ONE;
    w.hold = hold;
    return w;
  endfunction

  function automatic logic [CFG_W-1:0] rand_map(input bit all_known);
    logic [CFG_W-1:0] m;
    for (int c = 0; c < SLOTS; c++) begin
      if (!all_known && $urandom_range(0, 9) == 0)
        m[CODE_W*c +: CODE_W] = CODE_W'($urandom_range(8, 15));
      else
        m[CODE_W*c +: CODE_W] = CODE_W'($urandom_range(0, 7));
    end
    return m;
  endfunction

  // Input side: presents queued words and updates the prediction on accept.
  always @(posedge clk_i) begin
    logic v_next;
    if (rst_ni) begin
      v_next = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        mixer_apply(cur_word);
        v_next = 1'b0;
      end
      if (!v_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (in_words_q.size() != 0 &&
                     (!in_words_q[0].hold || bus_results_q.size() == 0)) begin
          cur_word = in_words_q.pop_front();
          op_i           <= cur_word.op;
          sample_left_i  <= cur_word.left;
          sample_right_i <= cur_word.right;
          bus_in_low_i   <= cur_word.bus_lo;
          bus_in_high_i  <= cur_word.bus_hi;
          coef_channel_i <= cur_word.ch;
          coef_side_i    <= cur_word.side;
          coef_value_i   <= cur_word.val;
          v_next = 1'b1;
          if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            gap_left = $urandom_range(1, 6);
        end
      end
      in_valid_i <= v_next;
    end
  end

  // Output side: checks each accepted word against the oldest prediction.
  always @(posedge clk_i) begin
    out_word_t want;
    logic      s_next;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (bus_results_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual pos %0d ch %0d bus %0d",
                   $time, position_o, channel_id_o, bus_out_o);
          errors++;
        end else begin
          want = bus_results_q.pop_front();
          check_field("position", want.pos, position_o);
          check_field("channel_id", want.ch, channel_id_o);
          check_field("bus_out", want.bus, bus_out_o);
          check_field("saturated", want.sat, saturated_o);
          check_field("last", want.last, last_o);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        s_next = 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 5);
        s_next = 1'b1;
      end else begin
        s_next = 1'b0;
      end
      out_stall_i <= s_next;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned n;
    in_word_t    w;
    for (int i = 0; i < TAB_DEPTH; i++) coef_tab[i] = '0;
    coef_tab[UNITY_LEFT_IDX]  = COEF_ONE;
    coef_tab[UNITY_RIGHT_IDX] = COEF_ONE;
    old_tab  = coef_tab;
    slew_pos = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_pct = 20;

    // Reset settings: two slots, unity routing, no ramp.
    in_words_q.push_back(mk_mix(16'h7FFF, 16'h8000, '0, '0));
    in_words_q.push_back(mk_mix(16'h7FFF, 16'h7FFF, {4{16'h7FFF}}, '0));
    in_words_q.push_back(mk_mix(16'h8000, 16'h8000, {4{16'h8000}}, '1));
    in_words_q.push_back(mk_ctl(OP_IGNORED));
    in_words_q.push_back(mk_coef(0, 1'b1, 16'h8000));
    in_words_q.push_back(mk_coef(1, 1'b0, 16'h7FFF));
    in_words_q.push_back(mk_coef(7, 1'b1, COEF_ONE));
    in_words_q.push_back(mk_mix(16'd1000, -16'sd2000, {$urandom, $urandom}, '0));
    in_words_q.push_back(mk_ctl(OP_BEGIN));
    in_words_q.push_back(mk_mix(16'hFFFF, 16'h0001, {$urandom, $urandom}, '0));
    wait_drained();

    // Short ramp over a map with unknown and out-of-range slot codes; the
    // last two frames run after the ramp has ended.
    write_reg(CFG_SLEW_FRAMES, 32'd4);
    write_reg(CFG_CHANNEL_COUNT, 32'd8);
    write_reg(CFG_CHANNEL_MAP, 32'h7A3F_2910);
    in_words_q.push_back(mk_coef(0, 1'b0, -COEF_ONE));
    in_words_q.push_back(mk_coef(3, 1'b0, 16'd8192));
    in_words_q.push_back(mk_ctl(OP_BEGIN));
    repeat (6) in_words_q.push_back(filler_word());
    wait_drained();

    // Ramp length below the position, and a count above the slot limit.
    write_reg(CFG_SLEW_FRAMES, 32'd2);
    write_reg(CFG_CHANNEL_COUNT, 32'd15);
    in_words_q.push_back(filler_word());
    wait_drained();

    // No known slot: nothing comes out, yet the ramp still moves on.
    write_reg(CFG_SLEW_FRAMES, 32'd3);
    write_reg(CFG_CHANNEL_COUNT, 32'd8);
    write_reg(CFG_CHANNEL_MAP, 32'hFFFF_FFFF);
    in_words_q.push_back(mk_ctl(OP_BEGIN));
    in_words_q.push_back(filler_word());
    wait_drained();
    write_reg(CFG_CHANNEL_MAP, 32'h7654_3210);
    in_words_q.push_back(filler_word());
    wait_drained();
    write_reg(CFG_CHANNEL_COUNT, 32'd0);
    in_words_q.push_back(filler_word());
    wait_drained();
    write_reg(CFG_CHANNEL_COUNT, 32'd8);
    write_reg(CFG_CHANNEL_MAP, 32'h0000_0000);
    in_words_q.push_back(filler_word());
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      idle_pct = (ph == RAND_PHASES - 1) ? 0 : $urandom_range(0, 30);
      case (ph)
        0:       write_reg(CFG_SLEW_FRAMES, 32'hFFFF);
        1:       write_reg(CFG_SLEW_FRAMES, 32'd1);
        2:       write_reg(CFG_SLEW_FRAMES, 32'd0);
        default: write_reg(CFG_SLEW_FRAMES, $urandom_range(2, 40));
      endcase
      if (ph == 0 || $urandom_range(0, 2) != 0)
        write_reg(CFG_CHANNEL_COUNT, $urandom_range(6, 8));
      else
        write_reg(CFG_CHANNEL_COUNT, $urandom_range(0, 15));
      write_reg(CFG_CHANNEL_MAP, rand_map(ph == 0));
      n = 0;
      while (n < PHASE_WORDS) begin
        w = rand_word(n == PHASE_WORDS / 2);
        if (w.op != OP_IGNORED) n++;
        in_words_q.push_back(w);
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
